/* sv/fdet_pkg.sv */
// Shared types, codes and helpers of the frontier cell detector.
package fdet_pkg;

  typedef enum logic [1:0] {
    CLS_PAD     = 2'd0,
    CLS_UNKNOWN = 2'd1,
    CLS_KNOWN   = 2'd2,
    CLS_OTHER   = 2'd3
  } cls_e;

  typedef enum logic [2:0] {
    CFG_GRID_WIDTH    = 3'd0,
    CFG_GRID_HEIGHT   = 3'd1,
    CFG_RADIUS_ENABLE = 3'd2,
    CFG_ROBOT_COL     = 3'd3,
    CFG_ROBOT_ROW     = 3'd4,
    CFG_RADIUS_SQ     = 3'd5
  } cfg_idx_e;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 34;

  localparam logic [7:0] VAL_UNKNOWN  = 8'hFF;
  localparam logic [7:0] VAL_FREE     = 8'd0;
  localparam logic [7:0] VAL_OCCUPIED = 8'd100;

  // One window column, top to bottom.
  typedef struct packed {
    cls_e top;
    cls_e mid;
    cls_e bot;
  } win_col_t;

  // One row store entry: class for the row above and for the current row.
  typedef struct packed {
    cls_e upper;
    cls_e middle;
  } row_ent_t;

  localparam win_col_t PAD_COL = '{top: CLS_PAD, mid: CLS_PAD, bot: CLS_PAD};

  function automatic cls_e classify(input logic [7:0] value);
    cls_e res;
    if (value == VAL_UNKNOWN) begin
      res = CLS_UNKNOWN;
    end else if (value == VAL_FREE || value == VAL_OCCUPIED) begin
      res = CLS_KNOWN;
    end else begin
      res = CLS_OTHER;
    end
    return res;
  endfunction

  function automatic logic is_frontier(input win_col_t lft, input win_col_t ctr,
                                       input win_col_t rgt);
    logic any_known;
    any_known = (lft.top == CLS_KNOWN) || (lft.mid == CLS_KNOWN) || (lft.bot == CLS_KNOWN) ||
                (ctr.top == CLS_KNOWN) || (ctr.bot == CLS_KNOWN) ||
                (rgt.top == CLS_KNOWN) || (rgt.mid == CLS_KNOWN) || (rgt.bot == CLS_KNOWN);
    return (ctr.mid == CLS_UNKNOWN) && any_known;
  endfunction

endpackage

/* sv/frontier_cell_detector_top.sv */
// Frontier cell detector: streaming 3x3 frontier search over an occupancy grid.
//
// Cells enter in raster order, one per cycle when both sides keep up. A single
// row store memory (MAX_WIDTH entries of two cell classes) is read ahead
// at the next input column, with a bypass when that column is the one just written;
// this read-ahead sets the one-cell-per-cycle rate. A result describes the cell one
// row plus one cell behind the input and leaves three register stages after its
// request is taken (window and frontier test, squares of the robot offsets, sum and
// radius compare). The whole pipeline holds while a result waits at the output.
// After the last grid cell, send drain requests to flush the remaining results;
// requests after the final result are taken and dropped until reset. Write the
// configuration only while no result is in flight.
module frontier_cell_detector_top
  import fdet_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic signed [7:0]     cell_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  frontier_o,
  output logic [9:0]            cell_col_o,
  output logic [9:0]            cell_row_o,
  output logic                  last_o
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT + 3);
  localparam int ORW   = $clog2(MAX_HEIGHT + 1);
  localparam int DW_WH = ($clog2(MAX_WIDTH + 1) > RW) ? $clog2(MAX_WIDTH + 1) : RW;
  localparam int DW    = (DW_WH > 11) ? DW_WH : 11;
  localparam int DXW   = ((CW + 4 > 16) ? CW + 4 : 16) + 2;
  localparam int DYW   = ((ORW + 4 > 16) ? ORW + 4 : 16) + 2;
  localparam int SQXW  = 2 * DXW;
  localparam int SQYW  = 2 * DYW;
  localparam int SUMW  = ((SQXW > SQYW) ? SQXW : SQYW) + 1;
  localparam int CMPW  = (SUMW > CFG_DATA_W) ? SUMW : CFG_DATA_W;

  typedef struct packed {
    logic           fr;
    logic           last;
    logic [CW-1:0]  col;
    logic [ORW-1:0] row;
  } pos_t;

  typedef struct packed {
    pos_t            pos;
    logic [SQXW-1:0] sqx;
    logic [SQYW-1:0] sqy;
  } sq_t;

  // configuration
  logic [10:0]           grid_width_q, grid_height_q;
  logic                  radius_enable_q;
  logic signed [15:0]    robot_col_q, robot_row_q;
  logic [CFG_DATA_W-1:0] radius_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q    <= 11'd1024;
      grid_height_q   <= 11'd1024;
      radius_enable_q <= 1'b0;
      robot_col_q     <= '0;
      robot_row_q     <= '0;
      radius_sq_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GRID_WIDTH:    grid_width_q    <= cfg_wdata_i[10:0];
        CFG_GRID_HEIGHT:   grid_height_q   <= cfg_wdata_i[10:0];
        CFG_RADIUS_ENABLE: radius_enable_q <= cfg_wdata_i[0];
        CFG_ROBOT_COL:     robot_col_q     <= cfg_wdata_i[15:0];
        CFG_ROBOT_ROW:     robot_row_q     <= cfg_wdata_i[15:0];
        CFG_RADIUS_SQ:     radius_sq_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [DW-1:0] w_eff, h_eff;
  assign w_eff = (grid_width_q == '0) ? DW'(1) :
                 ((DW'(grid_width_q) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(grid_width_q));
  assign h_eff = (grid_height_q == '0) ? DW'(1) :
                 ((DW'(grid_height_q) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) :
                  DW'(grid_height_q));

  // input side state
  logic [CW-1:0]  input_col_q, input_col_d;
  logic [RW-1:0]  input_row_q, input_row_d;
  logic [CW-1:0]  output_col_q, output_col_d;
  logic [ORW-1:0] output_row_q, output_row_d;
  logic           finished_q, finished_d;
  win_col_t       win1_q, win2_q, win1_d, win2_d;

  // row store
  row_ent_t row_mem [MAX_WIDTH];
  row_ent_t mem_rd_q, fwd_ent_q, fwd_ent_d, rd_ent, wr_ent;
  logic     fwd_q, fwd_d;

  logic adv, acc, upd, started, emit, wrap, last_c, fr_c;
  cls_e cls, top, mid;
  win_col_t new_col, right_col;
  logic [DW-1:0] ic_ext;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign acc        = in_valid_i && in_ready_o;
  assign upd        = acc && !finished_q;

  assign rd_ent = fwd_q ? fwd_ent_q : mem_rd_q;
  assign ic_ext = DW'(input_col_q);

  always_comb begin
    cls = CLS_PAD;
    if (!kind_i && (DW'(input_row_q) < h_eff)) begin
      cls = classify(cell_value_i);
    end
    top       = (input_row_q >= RW'(2)) ? rd_ent.upper : CLS_PAD;
    mid       = (input_row_q >= RW'(1)) ? rd_ent.middle : CLS_PAD;
    started   = (input_row_q >= RW'(2)) || (input_row_q == RW'(1) && input_col_q != '0);
    new_col   = '{top: top, mid: mid, bot: cls};
    right_col = (input_col_q == '0) ? PAD_COL : new_col;
    fr_c      = is_frontier(win1_q, win2_q, right_col);
    wrap      = (ic_ext + DW'(1)) >= w_eff;
    emit      = upd && started;
    last_c    = ((DW'(output_row_q) + DW'(1)) >= h_eff) &&
                ((DW'(output_col_q) + DW'(1)) >= w_eff);
    wr_ent    = '{upper: mid, middle: cls};

    win1_d       = win1_q;
    win2_d       = win2_q;
    input_col_d  = input_col_q;
    input_row_d  = input_row_q;
    output_col_d = output_col_q;
    output_row_d = output_row_q;
    finished_d   = finished_q;

    if (upd) begin
      if (input_col_q == '0) begin
        win1_d = PAD_COL;
      end else begin
        win1_d = win2_q;
      end
      win2_d = new_col;
      if (wrap) begin
        input_col_d = '0;
        if (DW'(input_row_q) < DW'(MAX_HEIGHT + 2)) begin
          input_row_d = input_row_q + RW'(1);
        end
      end else begin
        input_col_d = CW'(ic_ext + DW'(1));
      end
    end

    if (emit) begin
      if ((DW'(output_col_q) + DW'(1)) >= w_eff) begin
        output_col_d = '0;
        output_row_d = output_row_q + ORW'(1);
      end else begin
        output_col_d = output_col_q + CW'(1);
      end
      if (last_c) begin
        finished_d = 1'b1;
      end
    end

    fwd_d     = upd && (input_col_q == input_col_d);
    fwd_ent_d = wr_ent;
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      row_mem[input_col_q] <= wr_ent;
    end
    mem_rd_q  <= row_mem[input_col_d];
    fwd_ent_q <= fwd_ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q        <= 1'b0;
      win1_q       <= PAD_COL;
      win2_q       <= PAD_COL;
      input_col_q  <= '0;
      input_row_q  <= '0;
      output_col_q <= '0;
      output_row_q <= '0;
      finished_q   <= 1'b0;
    end else begin
      fwd_q        <= fwd_d;
      win1_q       <= win1_d;
      win2_q       <= win2_d;
      input_col_q  <= input_col_d;
      input_row_q  <= input_row_d;
      output_col_q <= output_col_d;
      output_row_q <= output_row_d;
      finished_q   <= finished_d;
    end
  end

  // result pipeline
  logic            s1_valid_q, s2_valid_q, out_valid_q;
  pos_t            s1_q;
  sq_t             s2_q;
  logic signed [DXW-1:0]  dx;
  logic signed [DYW-1:0]  dy;
  logic signed [SQXW-1:0] prod_x;
  logic signed [SQYW-1:0] prod_y;
  logic [SUMW-1:0] dist_sq;
  logic            in_rad;
  logic            frontier_q, last_q;
  logic [CW-1:0]   col_q;
  logic [ORW-1:0]  row_q;

  assign dx      = $signed(DXW'({s1_q.col, 4'b0000})) - DXW'(robot_col_q);
  assign dy      = $signed(DYW'({s1_q.row, 4'b0000})) - DYW'(robot_row_q);
  assign prod_x  = SQXW'(dx) * SQXW'(dx);
  assign prod_y  = SQYW'(dy) * SQYW'(dy);
  assign dist_sq = SUMW'(s2_q.sqx) + SUMW'(s2_q.sqy);
  assign in_rad  = !radius_enable_q || (CMPW'(dist_sq) <= CMPW'(radius_sq_q));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q     <= '{fr: fr_c, last: last_c, col: output_col_q, row: output_row_q};
      s2_q     <= '{pos: s1_q, sqx: $unsigned(prod_x), sqy: $unsigned(prod_y)};
      frontier_q <= s2_q.pos.fr && in_rad;
      last_q     <= s2_q.pos.last;
      col_q      <= s2_q.pos.col;
      row_q      <= s2_q.pos.row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= emit;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign frontier_o  = frontier_q;
  assign last_o      = last_q;
  assign cell_col_o  = 10'(col_q);
  assign cell_row_o  = 10'(row_q);

endmodule
